// File: hdl/tst_pkg.sv
// Shared types, widths and constants of the thermostat schedule table.
package tst_pkg;

  // Field widths.
  localparam int TEMP_W = 8;
  localparam int MIN_W  = 11;
  localparam int DAY_W  = 3;
  localparam int TAB_W  = 4;

  // Schedule geometry: two schedules of seven days.
  localparam int DAYS     = 7;
  localparam int TABLES   = 14;
  localparam int LAST_DAY = 6;

  // Request codes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ADD    = 1'b1;

  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [MIN_W-1:0]  minute_t;
  typedef logic [DAY_W-1:0]  day_t;
  typedef logic [TAB_W-1:0]  tab_t;

  // Table index of a schedule and day: heat tables first, then cool.
  function automatic tab_t tab_index(input logic hc, input day_t day);
    tab_t base;
    base = hc ? TAB_W'(DAYS) : '0;
    return base + TAB_W'(day);
  endfunction

  // The day before, with the first day wrapping to the last one.
  function automatic day_t prev_day(input day_t day);
    day_t prev;
    prev = (day == '0) ? DAY_W'(LAST_DAY) : day - DAY_W'(1);
    return prev;
  endfunction

endpackage

// File: hdl/tst_ram.sv
// Generic single-port RAM with registered read data.
module tst_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/thermostat_schedule_table.sv
// Top level of the thermostat schedule table: sequencer, counters and point RAM.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the single result word is shown for one cycle on the out_ ports with
// out_valid high. The receiver cannot stall, so the result is lost if not taken
// in that cycle. All set points live in one single-port RAM of 14*MAX_POINTS
// words, and one minute comparator walks a table one slot at a time: each slot
// visited is read, then compared, and each slot moved by an insert is read,
// then written. A request for weekday seven, an empty lookup or a full table
// is answered from the start state without reading the RAM.
// The default temperature is written through the cfg_ port, which is always
// ready; write it only while the block is idle.
module thermostat_schedule_table #(
  parameter int MAX_POINTS = 8
) (
  input  logic clk,
  input  logic rst_n,
  // Request channel.
  input  logic start,
  output logic busy,
  input  logic in_mode,
  input  logic in_heat_or_cool,
  input  logic [tst_pkg::DAY_W-1:0]  in_weekday,
  input  logic [tst_pkg::MIN_W-1:0]  in_minute_of_day,
  input  logic [tst_pkg::TEMP_W-1:0] in_set_temperature,
  // Result channel.
  output logic out_valid,
  output logic [tst_pkg::TEMP_W-1:0] out_scheduled_temperature,
  output logic out_accepted,
  // Configuration channel.
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tst_pkg::TEMP_W-1:0] cfg_default_temperature
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DEPTH  = tst_pkg::TABLES * MAX_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = tst_pkg::MIN_W + tst_pkg::TEMP_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SHR   = 3'd4;
  localparam logic [2:0] S_SHW   = 3'd5;
  localparam logic [2:0] S_INS   = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Request registers.
  logic             mode_r, mode_nxt;
  tst_pkg::day_t    day_r, day_nxt;
  tst_pkg::tab_t    tab_r, tab_nxt;
  tst_pkg::tab_t    prev_tab_r, prev_tab_nxt;
  tst_pkg::minute_t minute_r, minute_nxt;
  tst_pkg::temp_t   set_temp_r, set_temp_nxt;

  // Walk counters and running lookup value.
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  tst_pkg::temp_t   best_r, best_nxt;

  tst_pkg::temp_t   default_temp_r;
  logic [CNT_W-1:0] counts_r [tst_pkg::TABLES];
  tst_pkg::temp_t   last_day_r [tst_pkg::TABLES];

  // Per-table updates from the sequencer.
  logic             count_wr;
  logic             last_wr;
  tst_pkg::temp_t   last_val;

  // Result registers.
  logic           out_valid_r, out_valid_nxt;
  tst_pkg::temp_t out_temp_r, out_temp_nxt;
  logic           out_acc_r, out_acc_nxt;

  // Point RAM port.
  logic              ram_we;
  logic [CNT_W-1:0]  slot_sel;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  tst_pkg::minute_t rd_minute;
  tst_pkg::temp_t   rd_temp;
  logic [CNT_W-1:0] cnt_cur;
  logic             day_ok;
  logic [CNT_W-1:0] i_inc;
  logic [CNT_W-1:0] k_dec;

  assign rd_minute = ram_rdata[WORD_W-1:tst_pkg::TEMP_W];
  assign rd_temp   = ram_rdata[tst_pkg::TEMP_W-1:0];
  assign cnt_cur   = (tab_r < tst_pkg::TAB_W'(tst_pkg::TABLES)) ? counts_r[tab_r] : '0;
  assign day_ok    = (day_r < tst_pkg::DAY_W'(tst_pkg::DAYS));
  assign i_inc     = i_r + CNT_W'(1);
  assign k_dec     = k_r - CNT_W'(1);

  // Word address: table base plus slot.
  assign ram_addr = ADDR_W'(tab_r) * ADDR_W'(MAX_POINTS) + ADDR_W'(slot_sel[SLOT_W-1:0]);

  tst_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer: one slot read or written per cycle, one minute compare.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    day_nxt       = day_r;
    tab_nxt       = tab_r;
    prev_tab_nxt  = prev_tab_r;
    minute_nxt    = minute_r;
    set_temp_nxt  = set_temp_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    out_valid_nxt = 1'b0;
    out_temp_nxt  = out_temp_r;
    out_acc_nxt   = out_acc_r;
    count_wr      = 1'b0;
    last_wr       = 1'b0;
    last_val      = best_r;
    ram_we        = 1'b0;
    slot_sel      = i_r;
    ram_wdata     = {minute_r, set_temp_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt     = in_mode;
          day_nxt      = in_weekday;
          tab_nxt      = tst_pkg::tab_index(in_heat_or_cool, in_weekday);
          prev_tab_nxt = tst_pkg::tab_index(in_heat_or_cool,
                                            tst_pkg::prev_day(in_weekday));
          minute_nxt   = in_minute_of_day;
          set_temp_nxt = in_set_temperature;
          state_nxt    = S_START;
        end
      end

      S_START: begin
        n_nxt    = cnt_cur;
        i_nxt    = '0;
        best_nxt = default_temp_r;
        if (!day_ok) begin
          // Weekday seven has no table.
          out_valid_nxt = 1'b1;
          out_temp_nxt  = (mode_r == tst_pkg::MODE_LOOKUP) ? default_temp_r : '0;
          out_acc_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else if (mode_r == tst_pkg::MODE_LOOKUP) begin
          if (cnt_cur == '0) begin
            out_valid_nxt = 1'b1;
            out_temp_nxt  = default_temp_r;
            out_acc_nxt   = 1'b1;
            last_wr       = 1'b1;
            last_val      = default_temp_r;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          if (cnt_cur >= CNT_W'(MAX_POINTS)) begin
            out_valid_nxt = 1'b1;
            out_temp_nxt  = '0;
            out_acc_nxt   = 1'b0;
            state_nxt     = S_IDLE;
          end else if (cnt_cur == '0) begin
            state_nxt = S_INS;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt = S_CHK;
      end

      S_CHK: begin
        if (mode_r == tst_pkg::MODE_LOOKUP) begin
          if (rd_minute > minute_r) begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b1;
            state_nxt     = S_IDLE;
            if (i_r == '0) begin
              // The first point starts later: carry over the previous day.
              out_temp_nxt = last_day_r[prev_tab_r];
            end else begin
              out_temp_nxt = best_r;
              last_wr      = 1'b1;
              last_val     = best_r;
            end
          end else begin
            best_nxt = rd_temp;
            if (i_inc == n_r) begin
              out_valid_nxt = 1'b1;
              out_temp_nxt  = rd_temp;
              out_acc_nxt   = 1'b1;
              last_wr       = 1'b1;
              last_val      = rd_temp;
              state_nxt     = S_IDLE;
            end else begin
              i_nxt     = i_inc;
              state_nxt = S_RD;
            end
          end
        end else begin
          if (rd_minute < minute_r) begin
            i_nxt     = i_inc;
            state_nxt = (i_inc == n_r) ? S_INS : S_RD;
          end else if (rd_minute == minute_r) begin
            // Equal minute: replace the temperature in place.
            ram_we        = 1'b1;
            out_valid_nxt = 1'b1;
            out_temp_nxt  = '0;
            out_acc_nxt   = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            k_nxt     = n_r;
            state_nxt = S_SHR;
          end
        end
      end

      S_SHR: begin
        slot_sel  = k_dec;
        state_nxt = S_SHW;
      end

      S_SHW: begin
        // Move the word read last cycle up by one slot.
        slot_sel  = k_r;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        k_nxt     = k_dec;
        state_nxt = (k_dec == i_r) ? S_INS : S_SHR;
      end

      S_INS: begin
        ram_we        = 1'b1;
        count_wr      = 1'b1;
        out_valid_nxt = 1'b1;
        out_temp_nxt  = '0;
        out_acc_nxt   = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and per-table counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      default_temp_r <= '0;
      for (int t = 0; t < tst_pkg::TABLES; t++) begin
        counts_r[t]   <= '0;
        last_day_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        default_temp_r <= cfg_default_temperature;
      end
      if (count_wr) begin
        counts_r[tab_r] <= n_r + CNT_W'(1);
      end
      if (last_wr) begin
        last_day_r[tab_r] <= last_val;
      end
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    day_r      <= day_nxt;
    tab_r      <= tab_nxt;
    prev_tab_r <= prev_tab_nxt;
    minute_r   <= minute_nxt;
    set_temp_r <= set_temp_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    best_r     <= best_nxt;
    out_temp_r <= out_temp_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  assign busy                      = (state_r != S_IDLE);
  assign cfg_ready                 = 1'b1;
  assign out_valid                 = out_valid_r;
  assign out_scheduled_temperature = out_temp_r;
  assign out_accepted              = out_acc_r;

`ifndef ASSERT_OFF
  // A result is shown only once the sequencer is back at rest.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // An accepted request always enters the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_START))
    else $error("accepted request did not start");

  // The shift never writes a slot at or below the insert position.
  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHR || state_r == S_SHW) |-> (k_r > i_r))
    else $error("shift walked past insert position");

  // A table never holds more points than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |-> (cnt_cur <= CNT_W'(MAX_POINTS)))
    else $error("point count above table size");
`endif

endmodule
